// File: hdl/lav_pkg.sv
`timescale 1ns / 1ps
package lav_pkg;

    localparam int SQ_STEPS = 31;   // root bits of a 62-bit sum of squares
    localparam int DV_STEPS = 31;   // quotient bits of a normalized component
    localparam int MSB_TARGET = 29; // normalized maximum lies in [2^29, 2^30)

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [33:0] SAT_POS = 34'h0_7FFF_FFFF;
    localparam logic [33:0] SAT_NEG = 34'h0_8000_0000;

    typedef logic [2:0][31:0] vec32_t;
    typedef logic [2:0][63:0] vec64_t;

    // eye point and one more vector carried past a normalizer
    typedef struct packed {
        vec32_t eye;
        vec32_t aux;
    } side_t;

    typedef struct packed {
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
        side_t            side;
    } ncarry_t;

    function automatic logic [5:0] msb_pos(input logic [62:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 63; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // magnitude in units of 2^-30 rounded half up to whole units
    function automatic logic [33:0] rnd30(input logic [62:0] m);
        logic [63:0] t;
        t = 64'(m) + (64'(1) << 29);
        return t[63:30];
    endfunction

    function automatic logic [62:0] mag64(input logic [63:0] v);
        logic [63:0] n;
        n = -v;
        return v[63] ? n[62:0] : v[62:0];
    endfunction

endpackage

// File: hdl/lav_norm.sv
`timescale 1ns / 1ps
module lav_norm import lav_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   in_valid,
    input  vec64_t in_vec,
    input  side_t  in_side,
    output logic   out_valid,
    output vec32_t out_vec,
    output side_t  out_side
);

    logic             a_vld_reg;
    logic [2:0][62:0] a_mag_reg;
    logic [2:0]       a_neg_reg;
    side_t            a_side_reg;

    logic             b_vld_reg;
    ncarry_t          b_c_reg;
    ncarry_t          b_c_next;

    logic             c_vld_reg;
    logic [2:0][59:0] c_sq_reg;
    ncarry_t          c_c_reg;

    logic             sq_vld_reg  [0:SQ_STEPS];
    logic [61:0]      sq_rem_reg  [0:SQ_STEPS];
    logic [30:0]      sq_root_reg [0:SQ_STEPS];
    ncarry_t          sq_c_reg    [0:SQ_STEPS];
    logic [62:0]      sq_cand     [0:SQ_STEPS-1];

    logic             dv_vld_reg [0:DV_STEPS];
    logic [2:0][61:0] dv_rem_reg [0:DV_STEPS];
    logic [2:0][30:0] dv_q_reg   [0:DV_STEPS];
    logic [30:0]      dv_len_reg [0:DV_STEPS];
    ncarry_t          dv_c_reg   [0:DV_STEPS];

    logic             out_vld_reg;
    vec32_t           out_vec_reg;
    side_t            out_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= DV_STEPS; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            sq_vld_reg[0] <= c_vld_reg;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            for (int k = 1; k <= DV_STEPS; k++) begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            out_vld_reg <= dv_vld_reg[DV_STEPS];
        end
    end

    // scale all magnitudes by one shift so the largest has its top bit at 29
    always_comb begin
        logic [62:0] or_all;
        logic [62:0] shv;
        logic [5:0]  p;
        or_all = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        p = msb_pos(or_all);
        b_c_next.neg  = a_neg_reg;
        b_c_next.zero = (or_all == '0);
        b_c_next.side = a_side_reg;
        for (int i = 0; i < 3; i++) begin
            if (p >= 6'(MSB_TARGET)) begin
                shv = a_mag_reg[i] >> (p - 6'(MSB_TARGET));
            end else begin
                shv = a_mag_reg[i] << (6'(MSB_TARGET) - p);
            end
            b_c_next.m[i] = shv[29:0];
        end
    end

    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            sq_cand[k] = (63'(sq_root_reg[k]) << (SQ_STEPS - k))
                       + (63'(1) << (2 * (SQ_STEPS - 1 - k)));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                a_neg_reg[i] <= in_vec[i][63];
                a_mag_reg[i] <= mag64(in_vec[i]);
            end
            a_side_reg <= in_side;

            b_c_reg <= b_c_next;

            for (int i = 0; i < 3; i++) begin
                c_sq_reg[i] <= 60'(b_c_reg.m[i]) * 60'(b_c_reg.m[i]);
            end
            c_c_reg <= b_c_reg;

            sq_rem_reg[0]  <= 62'(c_sq_reg[0]) + 62'(c_sq_reg[1]) + 62'(c_sq_reg[2]);
            sq_root_reg[0] <= '0;
            sq_c_reg[0]    <= c_c_reg;
            // one root bit per stage, most significant first
            for (int k = 0; k < SQ_STEPS; k++) begin
                if ({1'b0, sq_rem_reg[k]} >= sq_cand[k]) begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k] - sq_cand[k][61:0];
                    sq_root_reg[k+1] <= sq_root_reg[k] | (31'(1) << (SQ_STEPS - 1 - k));
                end else begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k];
                    sq_root_reg[k+1] <= sq_root_reg[k];
                end
                sq_c_reg[k+1] <= sq_c_reg[k];
            end

            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= (62'(sq_c_reg[SQ_STEPS].m[i]) << 30)
                                  + 62'(sq_root_reg[SQ_STEPS] >> 1);
            end
            dv_q_reg[0]   <= '0;
            dv_len_reg[0] <= sq_root_reg[SQ_STEPS];
            dv_c_reg[0]   <= sq_c_reg[SQ_STEPS];
            // restoring division, one quotient bit per stage
            for (int k = 0; k < DV_STEPS; k++) begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_rem_reg[k][i] >= (62'(dv_len_reg[k]) << (DV_STEPS - 1 - k))) begin
                        dv_rem_reg[k+1][i] <= dv_rem_reg[k][i]
                                            - (62'(dv_len_reg[k]) << (DV_STEPS - 1 - k));
                        dv_q_reg[k+1][i]   <= dv_q_reg[k][i]
                                            | (31'(1) << (DV_STEPS - 1 - k));
                    end else begin
                        dv_rem_reg[k+1][i] <= dv_rem_reg[k][i];
                        dv_q_reg[k+1][i]   <= dv_q_reg[k][i];
                    end
                end
                dv_len_reg[k+1] <= dv_len_reg[k];
                dv_c_reg[k+1]   <= dv_c_reg[k];
            end

            for (int i = 0; i < 3; i++) begin
                if (dv_c_reg[DV_STEPS].zero) begin
                    out_vec_reg[i] <= '0;
                end else if (dv_c_reg[DV_STEPS].neg[i]) begin
                    out_vec_reg[i] <= -32'((dv_q_reg[DV_STEPS][i] > ONE_Q30) ?
                                           ONE_Q30 : dv_q_reg[DV_STEPS][i]);
                end else begin
                    out_vec_reg[i] <= 32'((dv_q_reg[DV_STEPS][i] > ONE_Q30) ?
                                          ONE_Q30 : dv_q_reg[DV_STEPS][i]);
                end
            end
            out_side_reg <= dv_c_reg[DV_STEPS].side;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

// File: hdl/lav_cross.sv
`timescale 1ns / 1ps
module lav_cross import lav_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   in_valid,
    input  vec32_t in_fwd,
    input  side_t  in_side,
    output logic   out_valid,
    output vec64_t out_vec,
    output side_t  out_side
);

    // up cross forward; in_side.aux carries up
    logic              p_vld_reg;
    logic signed [63:0] p_reg [0:5];
    side_t             p_side_reg;

    logic              r_vld_reg;
    vec64_t            r_vec_reg;
    side_t             r_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end else if (adv) begin
            p_vld_reg <= in_valid;
            r_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= 64'($signed(in_side.aux[1])) * 64'($signed(in_fwd[2]));
            p_reg[1] <= 64'($signed(in_side.aux[2])) * 64'($signed(in_fwd[1]));
            p_reg[2] <= 64'($signed(in_side.aux[2])) * 64'($signed(in_fwd[0]));
            p_reg[3] <= 64'($signed(in_side.aux[0])) * 64'($signed(in_fwd[2]));
            p_reg[4] <= 64'($signed(in_side.aux[0])) * 64'($signed(in_fwd[1]));
            p_reg[5] <= 64'($signed(in_side.aux[1])) * 64'($signed(in_fwd[0]));
            p_side_reg.eye <= in_side.eye;
            p_side_reg.aux <= in_fwd;

            for (int i = 0; i < 3; i++) begin
                r_vec_reg[i] <= 64'(p_reg[2*i] - p_reg[2*i+1]);
            end
            r_side_reg <= p_side_reg;
        end
    end

    assign out_valid = r_vld_reg;
    assign out_vec   = r_vec_reg;
    assign out_side  = r_side_reg;

endmodule

// File: hdl/lav_tail.sv
`timescale 1ns / 1ps
module lav_tail import lav_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   in_valid,
    input  vec32_t in_right,
    input  side_t  in_side,
    output logic   out_valid,
    output vec32_t out_right,
    output vec32_t out_upx,
    output vec32_t out_fwd,
    output vec32_t out_shift
);

    logic               t1_vld_reg, t2_vld_reg, t3_vld_reg;
    logic               t4_vld_reg, t5_vld_reg, t6_vld_reg;
    logic signed [63:0] t1_p_reg [0:5];
    logic signed [63:0] t2_uc_reg [0:2];
    logic signed [63:0] t4_p_reg [0:8];
    logic signed [63:0] t5_s_reg [0:2];
    vec32_t             t1_r_reg, t2_r_reg, t3_r_reg, t4_r_reg, t5_r_reg, t6_r_reg;
    vec32_t             t1_f_reg, t2_f_reg, t3_f_reg, t4_f_reg, t5_f_reg, t6_f_reg;
    vec32_t             t1_e_reg, t2_e_reg, t3_e_reg;
    vec32_t             t3_u_reg, t4_u_reg, t5_u_reg, t6_u_reg;
    vec32_t             t6_s_reg;
    vec32_t             axes [0:2];
    logic [33:0]        u_rnd [0:2];
    logic [33:0]        s_rnd [0:2];

    assign axes[0] = t3_r_reg;
    assign axes[1] = t3_u_reg;
    assign axes[2] = t3_f_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_rnd[i] = rnd30(mag64(t2_uc_reg[i]));
            s_rnd[i] = rnd30(mag64(t5_s_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
            t3_vld_reg <= 1'b0;
            t4_vld_reg <= 1'b0;
            t5_vld_reg <= 1'b0;
            t6_vld_reg <= 1'b0;
        end else if (adv) begin
            t1_vld_reg <= in_valid;
            t2_vld_reg <= t1_vld_reg;
            t3_vld_reg <= t2_vld_reg;
            t4_vld_reg <= t3_vld_reg;
            t5_vld_reg <= t4_vld_reg;
            t6_vld_reg <= t5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // forward cross right
            t1_p_reg[0] <= 64'($signed(in_side.aux[1])) * 64'($signed(in_right[2]));
            t1_p_reg[1] <= 64'($signed(in_side.aux[2])) * 64'($signed(in_right[1]));
            t1_p_reg[2] <= 64'($signed(in_side.aux[2])) * 64'($signed(in_right[0]));
            t1_p_reg[3] <= 64'($signed(in_side.aux[0])) * 64'($signed(in_right[2]));
            t1_p_reg[4] <= 64'($signed(in_side.aux[0])) * 64'($signed(in_right[1]));
            t1_p_reg[5] <= 64'($signed(in_side.aux[1])) * 64'($signed(in_right[0]));
            t1_r_reg <= in_right;
            t1_f_reg <= in_side.aux;
            t1_e_reg <= in_side.eye;

            for (int i = 0; i < 3; i++) begin
                t2_uc_reg[i] <= t1_p_reg[2*i] - t1_p_reg[2*i+1];
            end
            t2_r_reg <= t1_r_reg;
            t2_f_reg <= t1_f_reg;
            t2_e_reg <= t1_e_reg;

            // round Q4.60 to Q2.30, ties away from zero, clamp at one
            for (int i = 0; i < 3; i++) begin
                if (u_rnd[i] > 34'(ONE_Q30)) begin
                    t3_u_reg[i] <= t2_uc_reg[i][63] ? -32'(ONE_Q30) : 32'(ONE_Q30);
                end else if (t2_uc_reg[i][63]) begin
                    t3_u_reg[i] <= -u_rnd[i][31:0];
                end else begin
                    t3_u_reg[i] <= u_rnd[i][31:0];
                end
            end
            t3_r_reg <= t2_r_reg;
            t3_f_reg <= t2_f_reg;
            t3_e_reg <= t2_e_reg;

            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    t4_p_reg[3*a+i] <= 64'($signed(axes[a][i])) * 64'($signed(t3_e_reg[i]));
                end
            end
            t4_r_reg <= t3_r_reg;
            t4_u_reg <= t3_u_reg;
            t4_f_reg <= t3_f_reg;

            for (int a = 0; a < 3; a++) begin
                t5_s_reg[a] <= t4_p_reg[3*a] + t4_p_reg[3*a+1] + t4_p_reg[3*a+2];
            end
            t5_r_reg <= t4_r_reg;
            t5_u_reg <= t4_u_reg;
            t5_f_reg <= t4_f_reg;

            // round to Q16.16, negate, saturate
            for (int a = 0; a < 3; a++) begin
                if (!t5_s_reg[a][63]) begin
                    if (s_rnd[a] > SAT_NEG) begin
                        t6_s_reg[a] <= SAT_NEG[31:0];
                    end else begin
                        t6_s_reg[a] <= -s_rnd[a][31:0];
                    end
                end else begin
                    if (s_rnd[a] > SAT_POS) begin
                        t6_s_reg[a] <= SAT_POS[31:0];
                    end else begin
                        t6_s_reg[a] <= s_rnd[a][31:0];
                    end
                end
            end
            t6_r_reg <= t5_r_reg;
            t6_u_reg <= t5_u_reg;
            t6_f_reg <= t5_f_reg;
        end
    end

    assign out_valid = t6_vld_reg;
    assign out_right = t6_r_reg;
    assign out_upx   = t6_u_reg;
    assign out_fwd   = t6_f_reg;
    assign out_shift = t6_s_reg;

endmodule

// File: hdl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// Path from an accepted request to m_tvalid: two 68-stage
// normalizers, each a one-bit-per-stage square root and divider, plus cross
// product and output stages. Throughput: one request per cycle.
// The whole pipeline holds while a result waits on m_tready.
// Reset clears all valid bits; no result is pending after reset.
module look_at_view_matrix import lav_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_x/y/z, upaxis_x/y/z, forward_x/y/z, shift_x/y/z
    output logic [383:0] m_tdata
);

    logic   adv;
    vec32_t eye, target, up;
    vec64_t d_vec;
    side_t  n1_side_in;

    logic   n1_valid;
    vec32_t n1_fwd;
    side_t  n1_side;

    logic   cr_valid;
    vec64_t cr_vec;
    side_t  cr_side;

    logic   n2_valid;
    vec32_t n2_right;
    side_t  n2_side;

    vec32_t o_right, o_upx, o_fwd, o_shift;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign eye    = s_tdata[95:0];
    assign target = s_tdata[191:96];
    assign up     = s_tdata[287:192];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_vec[i] = 64'($signed(target[i])) - 64'($signed(eye[i]));
        end
        n1_side_in.eye = eye;
        n1_side_in.aux = up;
    end

    lav_norm u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_vec    (d_vec),
        .in_side   (n1_side_in),
        .out_valid (n1_valid),
        .out_vec   (n1_fwd),
        .out_side  (n1_side)
    );

    lav_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (n1_valid),
        .in_fwd    (n1_fwd),
        .in_side   (n1_side),
        .out_valid (cr_valid),
        .out_vec   (cr_vec),
        .out_side  (cr_side)
    );

    lav_norm u_norm_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (cr_valid),
        .in_vec    (cr_vec),
        .in_side   (cr_side),
        .out_valid (n2_valid),
        .out_vec   (n2_right),
        .out_side  (n2_side)
    );

    lav_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (n2_valid),
        .in_right  (n2_right),
        .in_side   (n2_side),
        .out_valid (m_tvalid),
        .out_right (o_right),
        .out_upx   (o_upx),
        .out_fwd   (o_fwd),
        .out_shift (o_shift)
    );

    assign m_tdata = {o_shift, o_fwd, o_upx, o_right};

endmodule
